>>> sv/max_heap_priority_queue_core_assert.svh
// assertion macros for the max heap priority queue core
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("heap queue check failed");

// next-cycle implication, checked at every rising edge out of reset
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("heap queue check failed");

`endif

>>> sv/mhpq_pkg.sv
// shared types and codes for the max heap priority queue core
package mhpq_pkg;

	localparam int DATA_W = 32;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// largest signed value, used as the sentinel above the first cell
	localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	// operation broadcast to every cell in the row
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

	// what one cell sees of its neighbour
	typedef struct packed {
		logic                     occ;
		logic signed [DATA_W-1:0] value;
	} nbr_t;

endpackage

>>> sv/max_heap_priority_queue_core.sv
// max heap priority queue: a command updates the cell row as it is accepted, and the result follows in the next cycle
// a row of CAPACITY cells keeps the values sorted, largest at the head; every
// cell compares with the broadcast value and its upper neighbour in the same cycle
// latency: result strobe in the cycle after the command transfer
// throughput: one command every cycle, busy stays low
// reset clears the count and the strobe; cell contents stay undefined until written
module max_heap_priority_queue_core #(
	parameter int CAPACITY = 64,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic signed [mhpq_pkg::DATA_W-1:0]   new_value,
	output logic                                 done,
	output logic signed [mhpq_pkg::DATA_W-1:0]   removed_value,
	output logic signed [mhpq_pkg::DATA_W-1:0]   top_value,
	output logic        [CNT_W-1:0]              entry_count,
	output logic        [1:0]                    status
);

	logic                                  accept;
	logic                                  empty;
	logic                                  full;
	logic [CNT_W-1:0]                      count_q;
	mhpq_pkg::cell_ctrl_t                  ctrl;
	logic signed [mhpq_pkg::DATA_W-1:0]    cell_value [CAPACITY];
	logic                                  cell_occ   [CAPACITY];

	logic                                  done_q;
	logic signed [mhpq_pkg::DATA_W-1:0]    removed_q;
	logic signed [mhpq_pkg::DATA_W-1:0]    top_q;
	logic [CNT_W-1:0]                      entry_count_q;
	logic [1:0]                            status_q;

	// command transfer and heap condition
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(CAPACITY));

	// broadcast to the row
	always_comb begin
		ctrl.ins   = accept && (command == mhpq_pkg::CMD_INSERT) && !full;
		ctrl.del   = accept && (command == mhpq_pkg::CMD_DELETE) && !empty;
		ctrl.value = new_value;
	end

	// row of cells, sentinel above the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mhpq_pkg::nbr_t                     up;
		logic signed [mhpq_pkg::DATA_W-1:0] down_value;

		assign cell_occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign up.occ   = 1'b1;
			assign up.value = mhpq_pkg::VALUE_MAX;
		end else begin : g_body
			assign up.occ   = cell_occ[i-1];
			assign up.value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign down_value = cell_value[i];
		end else begin : g_inner
			assign down_value = cell_value[i+1];
		end

		mhpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occ        (cell_occ[i]),
			.up         (up),
			.down_value (down_value),
			.value      (cell_value[i])
		);
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.del) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// result payload, worked out from the state before the update
	always_ff @(posedge clk) begin
		if (accept) begin
			if (command == mhpq_pkg::CMD_DELETE) begin
				if (empty) begin
					removed_q     <= '0;
					top_q         <= '0;
					entry_count_q <= '0;
					status_q      <= mhpq_pkg::ST_EMPTY;
				end else begin
					removed_q     <= cell_value[0];
					top_q         <= (count_q > CNT_W'(1)) ? cell_value[1] : '0;
					entry_count_q <= count_q - CNT_W'(1);
					status_q      <= mhpq_pkg::ST_DONE;
				end
			end else begin
				if (full) begin
					removed_q     <= '0;
					top_q         <= cell_value[0];
					entry_count_q <= count_q;
					status_q      <= mhpq_pkg::ST_FULL;
				end else begin
					removed_q     <= '0;
					top_q         <= (!empty && (cell_value[0] >= new_value)) ?
					                 cell_value[0] : new_value;
					entry_count_q <= count_q + CNT_W'(1);
					status_q      <= mhpq_pkg::ST_DONE;
				end
			end
		end
	end

	assign done          = done_q;
	assign removed_value = removed_q;
	assign top_value     = top_q;
	assign entry_count   = entry_count_q;
	assign status        = status_q;

	`include "max_heap_priority_queue_core_assert.svh"

	// count never runs past capacity
	`MHPQ_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	// head of the row is never smaller than the next occupied cell
	`MHPQ_ASSERT_NOW(a_head_order, clk, arst_n, count_q >= CNT_W'(2),
		cell_value[0] >= cell_value[1])
	// a delete on an empty heap reports so and leaves the count alone
	`MHPQ_ASSERT_NEXT(a_empty_delete, clk, arst_n,
		accept && (command == mhpq_pkg::CMD_DELETE) && empty,
		done && (status == mhpq_pkg::ST_EMPTY) && (count_q == '0))
	// reported count matches the stored count with every result strobe
	`MHPQ_ASSERT_NOW(a_count_match, clk, arst_n, done, entry_count == count_q)

endmodule

>>> sv/mhpq_cell.sv
// one cell of the sorted row: holds one value and trades it with its neighbours
module mhpq_cell (
	input  logic                                     clk,
	input  mhpq_pkg::cell_ctrl_t                     ctrl,
	input  logic                                     occ,
	input  mhpq_pkg::nbr_t                           up,
	input  logic signed [mhpq_pkg::DATA_W-1:0]       down_value,
	output logic signed [mhpq_pkg::DATA_W-1:0]       value
);

	logic signed [mhpq_pkg::DATA_W-1:0] value_q;
	logic signed [mhpq_pkg::DATA_W-1:0] value_d;

	// insert: keep if not smaller, take the new value at the gap, else shift down
	// delete: everything moves one place towards the head
	always_comb begin
		value_d = value_q;
		if (ctrl.del) begin
			value_d = down_value;
		end else if (ctrl.ins) begin
			if (occ && (value_q >= ctrl.value)) begin
				value_d = value_q;
			end else if (up.occ && (up.value >= ctrl.value)) begin
				value_d = ctrl.value;
			end else begin
				value_d = up.value;
			end
		end
	end

	// value register, payload only
	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the max heap priority queue core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W   = mhpq_pkg::DATA_W;
	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// one result as the core reports it
	typedef struct packed {
		logic signed [DATA_W-1:0] removed;
		logic signed [DATA_W-1:0] top;
		logic        [CNT_W-1:0]  count;
		logic        [1:0]        status;
	} heap_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     command;
	logic signed [DATA_W-1:0] new_value;
	logic                     done;
	logic signed [DATA_W-1:0] removed_value;
	logic signed [DATA_W-1:0] top_value;
	logic        [CNT_W-1:0]  entry_count;
	logic        [1:0]        status;

	// predictor state: 1-based heap positions and element count
	logic signed [DATA_W-1:0] heap_mem [1:CAPACITY];
	int                       heap_size;

	heap_result_t pending_results [$];
	int           mismatch_count;
	int           send_idle_pct;

	max_heap_priority_queue_core #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.new_value    (new_value),
		.done         (done),
		.removed_value(removed_value),
		.top_value    (top_value),
		.entry_count  (entry_count),
		.status       (status)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// apply one command to the predicted heap and return the expected result
	function automatic heap_result_t heap_apply(input logic cmd,
			input logic signed [DATA_W-1:0] val);
		heap_result_t             res;
		int                       pos;
		int                       best;
		logic signed [DATA_W-1:0] tmp;
		res = '0;
		res.status = mhpq_pkg::ST_DONE;
		if (cmd == mhpq_pkg::CMD_DELETE) begin
			if (heap_size == 0) begin
				res.status = mhpq_pkg::ST_EMPTY;
			end else begin
				res.removed = heap_mem[1];
				heap_mem[1] = heap_mem[heap_size];
				heap_size--;
				// sift down toward the strictly larger child, left on a tie
				pos = 1;
				forever begin
					best = pos;
					if (2 * pos <= heap_size && heap_mem[2 * pos] > heap_mem[best])
						best = 2 * pos;
					if (2 * pos + 1 <= heap_size && heap_mem[2 * pos + 1] > heap_mem[best])
						best = 2 * pos + 1;
					if (best == pos)
						break;
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[best];
					heap_mem[best] = tmp;
					pos = best;
				end
			end
		end else begin
			if (heap_size >= CAPACITY) begin
				res.status = mhpq_pkg::ST_FULL;
			end else begin
				heap_size++;
				heap_mem[heap_size] = val;
				// sift up past strictly smaller parents
				pos = heap_size;
				while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2]) begin
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[pos / 2];
					heap_mem[pos / 2] = tmp;
					pos = pos / 2;
				end
			end
		end
		res.top = (heap_size > 0) ? heap_mem[1] : '0;
		res.count = heap_size[CNT_W-1:0];
		return res;
	endfunction

	// mixed value source: full range, tight cluster for equal keys, extremes
	function automatic logic signed [DATA_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return $urandom;
		else if (sel < 80)
			return $signed($urandom_range(6)) - 3;
		else if (sel < 88)
			return mhpq_pkg::VALUE_MAX - $urandom_range(2);
		else if (sel < 96)
			return VALUE_MIN + $urandom_range(2);
		else
			return '0;
	endfunction

	task automatic note_mismatch(input string what, input longint exp_v, input longint act_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch %s: expected %0d actual %0d", $realtime, what, exp_v, act_v);
	endtask

	// result checker: every strobe must match the oldest outstanding prediction
	always @(posedge clk) begin
		heap_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result, count", -1, entry_count);
			end else begin
				exp_r = pending_results.pop_front();
				if (removed_value !== exp_r.removed)
					note_mismatch("removed_value", exp_r.removed, removed_value);
				if (top_value !== exp_r.top)
					note_mismatch("top_value", exp_r.top, top_value);
				if (entry_count !== exp_r.count)
					note_mismatch("entry_count", exp_r.count, entry_count);
				if (status !== exp_r.status)
					note_mismatch("status", exp_r.status, status);
			end
		end
	end

	// random idle cycles on the command side
	task automatic sender_gap();
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			command <= 1'($urandom);
			new_value <= $urandom;
		end
	endtask

	// one command transfer; start is left high for a back-to-back follower
	task automatic send_cmd(input logic cmd, input logic signed [DATA_W-1:0] val);
		sender_gap();
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		new_value <= val;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(heap_apply(cmd, val));
	endtask

	// hold off until every predicted result has been seen
	task automatic wait_all_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// extremes, every command, empty delete and equal keys
	task automatic test_directed();
		send_cmd(mhpq_pkg::CMD_DELETE, 32'sd7);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sd0);
		send_cmd(mhpq_pkg::CMD_INSERT, -32'sd1);
		send_cmd(mhpq_pkg::CMD_INSERT, mhpq_pkg::VALUE_MAX);
		send_cmd(mhpq_pkg::CMD_INSERT, VALUE_MIN);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sd5);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sd5);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sd5);
		send_cmd(mhpq_pkg::CMD_DELETE, mhpq_pkg::VALUE_MAX);
		send_cmd(mhpq_pkg::CMD_DELETE, 32'sd0);
		send_cmd(mhpq_pkg::CMD_INSERT, 32'sd5);
		send_cmd(mhpq_pkg::CMD_INSERT, -32'sd7);
		send_cmd(mhpq_pkg::CMD_INSERT, -32'sd7);
		repeat (9) send_cmd(mhpq_pkg::CMD_DELETE, $urandom);
		send_cmd(mhpq_pkg::CMD_DELETE, $urandom);
		wait_all_results();
	endtask

	// fill to capacity, then keep pushing so full inserts recur
	task automatic test_fill_overflow();
		while (heap_size < CAPACITY)
			send_cmd(mhpq_pkg::CMD_INSERT, pick_value());
		repeat (86)
			send_cmd(($urandom_range(99) < 70) ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_DELETE,
				pick_value());
		wait_all_results();
	endtask

	// drain to empty, with deletes on an empty heap
	task automatic test_drain_underflow();
		repeat (150)
			send_cmd(($urandom_range(99) < 75) ? mhpq_pkg::CMD_DELETE : mhpq_pkg::CMD_INSERT,
				pick_value());
		wait_all_results();
	endtask

	// balanced traffic in bursts, with occasional pauses for all results
	task automatic test_mixed();
		int burst;
		int ins_pct;
		repeat (12) begin
			burst = $urandom_range(6, 20);
			ins_pct = $urandom_range(20, 80);
			repeat (burst)
				send_cmd(($urandom_range(99) < ins_pct) ?
					mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_DELETE, pick_value());
			if ($urandom_range(3) == 0)
				wait_all_results();
		end
		wait_all_results();
	endtask

	// run limit
	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	// reset then tests in turn
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = mhpq_pkg::CMD_INSERT;
		new_value = '0;
		heap_size = 0;
		mismatch_count = 0;
		send_idle_pct = 19;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_fill_overflow();
		send_idle_pct = 57;
		test_drain_underflow();
		send_idle_pct = 0;
		test_mixed();

		wait_all_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
